// File: rtl/core/dfs_path_finder_macros.svh
// ----------------------------------------------------------------------------
// dfs_path_finder assertion macros
// Concurrent assertion shorthands used by the path finder walk sequencer (dfs_walk).
// ----------------------------------------------------------------------------
`ifndef DFS_PATH_FINDER_MACROS_SVH
`define DFS_PATH_FINDER_MACROS_SVH

// property holds at every clock edge outside reset
`define DFS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// cond in one cycle implies nxt in the following cycle
`define DFS_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
		else $error(msg);

`endif

// File: rtl/core/dfs_pkg.sv
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared types and constants of the depth-first path finder.
// ----------------------------------------------------------------------------
`default_nettype none

package dfs_pkg;

	localparam int MaxVerticesDef = 16;
	localparam int VertexW        = 4;   // width of a vertex field on the ports
	localparam int CountW         = 5;   // width of vertex_count
	localparam int PathDepth      = 16;
	localparam int PathIdxW       = 4;
	localparam int LenW           = 5;
	localparam int STdataW        = 16;
	localparam int MTdataW        = 8;

	localparam logic [CountW-1:0] VertexCountReset = CountW'(16);

	typedef enum logic {
		CMD_WRITE  = 1'b0,
		CMD_SEARCH = 1'b1
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_SCAN,
		ST_POP,
		ST_CHECK,
		ST_PATH,
		ST_PARENT,
		ST_EMIT,
		ST_MISS
	} dfs_state_t;

	// adjacency store write control
	typedef struct packed {
		logic clr;       // zero a whole row
		logic wr_en;     // write one edge bit
		logic edge_val;
	} adj_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/dfs_path_finder.sv
// ----------------------------------------------------------------------------
// dfs_path_finder
// Depth-first path search over a directed adjacency bit matrix.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    contents
//  s_axis    in   s_axis_tvalid/s_axis_tready  edge write or search request
//  m_axis    out  m_axis_tvalid/m_axis_tready  path vertices or not-found
//  cfg       in   cfg_wr_en                    vertex_count
//
//  Search: one column test per cycle on the current stack top, with a FETCH
//  state after each push and POP then FETCH after each exhausted row but the
//  source's; the path is then traced back through PATH and PARENT states and
//  emitted vertex by vertex. After reset a clearing pass zeroes the matrix,
//  one row per cycle, with s_axis_tready low.
//  A stalled m_axis holds the sequencer; no new request is taken until the
//  last transfer of a search is loaded into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_path_finder import dfs_pkg::*; #(
	parameter int MAX_VERTICES = MaxVerticesDef
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic [CountW-1:0]  cfg_wr_data,    // vertex_count
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [STdataW-1:0] s_axis_tdata,   // from_vertex, to_vertex, edge_present
	input  wire logic               s_axis_tuser,   // command
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	output logic      [MTdataW-1:0] m_axis_tdata,   // path_vertex
	output logic                    m_axis_tuser,   // found
	output logic                    m_axis_tlast
);

	localparam int VW = $clog2(MAX_VERTICES);

	logic [CountW-1:0]       vertex_count_q;
	adj_ctl_t                adj_ctl;
	logic [VW-1:0]           adj_wr_row, adj_wr_col, adj_rd_row;
	logic [MAX_VERTICES-1:0] adj_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VertexCountReset;
		end else if (cfg_wr_en) begin
			vertex_count_q <= cfg_wr_data;
		end
	end

	dfs_adj_ram #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_adj (
		.clk     (clk),
		.ctl     (adj_ctl),
		.wr_row  (adj_wr_row),
		.wr_col  (adj_wr_col),
		.rd_row  (adj_rd_row),
		.rd_data (adj_row)
	);

	dfs_walk #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_walk (
		.clk           (clk),
		.arst_n        (arst_n),
		.vertex_count  (vertex_count_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.adj_ctl       (adj_ctl),
		.adj_wr_row    (adj_wr_row),
		.adj_wr_col    (adj_wr_col),
		.adj_rd_row    (adj_rd_row),
		.adj_row       (adj_row)
	);

endmodule

`default_nettype wire

// File: rtl/core/dfs_adj_ram.sv
// ----------------------------------------------------------------------------
// dfs_adj_ram
// Adjacency bit matrix: one row per source vertex, bit writes, row clears, registered row read.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_adj_ram import dfs_pkg::*; #(
	parameter int MAX_VERTICES = MaxVerticesDef
) (
	input  wire logic                            clk,
	input  wire adj_ctl_t                        ctl,
	input  wire logic [$clog2(MAX_VERTICES)-1:0] wr_row,
	input  wire logic [$clog2(MAX_VERTICES)-1:0] wr_col,
	input  wire logic [$clog2(MAX_VERTICES)-1:0] rd_row,
	output logic      [MAX_VERTICES-1:0]         rd_data
);

	logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			adj_mem[wr_row] <= '0;
		end else if (ctl.wr_en) begin
			adj_mem[wr_row][wr_col] <= ctl.edge_val;
		end
		rd_data_q <= adj_mem[rd_row];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/core/dfs_walk.sv
// ----------------------------------------------------------------------------
// dfs_walk
// Search sequencer: column scan unit, walk stack, parent chain, path output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dfs_path_finder_macros.svh"

module dfs_walk import dfs_pkg::*; #(
	parameter int MAX_VERTICES = MaxVerticesDef
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [CountW-1:0]               vertex_count,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [STdataW-1:0]              s_axis_tdata,
	input  wire logic                            s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic      [MTdataW-1:0]              m_axis_tdata,
	output logic                                 m_axis_tuser,
	output logic                                 m_axis_tlast,
	output adj_ctl_t                             adj_ctl,
	output logic      [$clog2(MAX_VERTICES)-1:0] adj_wr_row,
	output logic      [$clog2(MAX_VERTICES)-1:0] adj_wr_col,
	output logic      [$clog2(MAX_VERTICES)-1:0] adj_rd_row,
	input  wire logic [MAX_VERTICES-1:0]         adj_row
);

	localparam int VW   = $clog2(MAX_VERTICES);
	localparam int NW   = $clog2(MAX_VERTICES + 1);
	localparam int CMPW = (NW > CountW) ? NW : CountW;

	typedef struct packed {
		logic [VW-1:0] v;
		logic [NW-1:0] j;
	} stk_ent_t;

	dfs_state_t state_q, state_d;

	logic [VW-1:0]           clr_cnt_q;
	logic [VW-1:0]           sp_q;       // entries below the top
	logic [MAX_VERTICES-1:0] visited_q;
	logic                    m_valid_q;

	logic [VW-1:0]       src_q, dst_q, top_v_q, cur_q;
	logic [NW-1:0]       n_q, top_j_q;
	logic [LenW-1:0]     len_q;
	logic [PathIdxW-1:0] idx_q;
	logic [VertexW-1:0]  m_vertex_q;
	logic                m_found_q, m_last_q;

	stk_ent_t      stk_mem [MAX_VERTICES];
	stk_ent_t      stk_rd_q;
	logic [VW-1:0] parent_mem [MAX_VERTICES];
	logic [VW-1:0] par_rd_q;
	logic [VertexW-1:0] path_buf [PathDepth];

	logic [VertexW-1:0] from_v, to_v;
	logic [CMPW-1:0]    from_c, to_c, vc_c, max_c, n_c;
	logic               wr_in_range, sr_in_range;
	logic               accept, is_search;
	logic [VW-1:0]      col_j, stk_raddr;
	logic               scan_end, hit, push, out_free, load_out;

	assign from_v = s_axis_tdata[VertexW-1:0];
	assign to_v   = s_axis_tdata[2*VertexW-1:VertexW];
	assign from_c = CMPW'(from_v);
	assign to_c   = CMPW'(to_v);
	assign vc_c   = CMPW'(vertex_count);
	assign max_c  = CMPW'(MAX_VERTICES);
	assign n_c    = (vc_c < max_c) ? vc_c : max_c;

	assign wr_in_range = (from_c < max_c) && (to_c < max_c);
	assign sr_in_range = (from_c < n_c) && (to_c < n_c);
	assign accept      = s_axis_tvalid && s_axis_tready;
	assign is_search   = (s_axis_tuser == CMD_SEARCH);

	// one column of the current row per cycle
	assign col_j     = top_j_q[VW-1:0];
	assign scan_end  = (top_j_q >= n_q);
	assign hit       = adj_row[col_j] && !visited_q[col_j];
	assign push      = (state_q == ST_SCAN) && !scan_end && hit;
	assign stk_raddr = sp_q - VW'(1);
	assign adj_rd_row = top_v_q;

	assign out_free = !m_valid_q || m_axis_tready;
	assign load_out = ((state_q == ST_EMIT) || (state_q == ST_MISS)) && out_free;

	always_comb begin
		state_d        = state_q;
		s_axis_tready  = 1'b0;
		adj_ctl        = '0;
		adj_wr_row     = '0;
		adj_wr_col     = '0;
		case (state_q)
			ST_CLEAR: begin
				adj_ctl.clr = 1'b1;
				adj_wr_row  = clr_cnt_q;
				if (clr_cnt_q == VW'(MAX_VERTICES - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				adj_wr_row    = VW'(from_v);
				adj_wr_col    = VW'(to_v);
				adj_ctl.edge_val = s_axis_tdata[2*VertexW];
				if (s_axis_tvalid) begin
					if (is_search) begin
						state_d = sr_in_range ? ST_FETCH : ST_MISS;
					end else begin
						adj_ctl.wr_en = wr_in_range;
					end
				end
			end
			ST_FETCH:  state_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_end) begin
					state_d = (sp_q == '0) ? ST_CHECK : ST_POP;
				end else if (hit) begin
					state_d = ST_FETCH;
				end
			end
			ST_POP:    state_d = ST_FETCH;
			ST_CHECK:  state_d = visited_q[dst_q] ? ST_PATH : ST_MISS;
			ST_PATH:   state_d = (cur_q == src_q) ? ST_EMIT : ST_PARENT;
			ST_PARENT: state_d = ST_PATH;
			ST_EMIT: begin
				if (out_free && (idx_q == '0)) state_d = ST_IDLE;
			end
			ST_MISS: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			sp_q      <= '0;
			visited_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + VW'(1);
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (accept && is_search) begin
				visited_q <= MAX_VERTICES'(1) << VW'(from_v);
				sp_q      <= '0;
			end
			if (push) begin
				visited_q[col_j] <= 1'b1;
				sp_q             <= sp_q + VW'(1);
			end else if ((state_q == ST_SCAN) && scan_end && (sp_q != '0)) begin
				sp_q <= stk_raddr;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && is_search) begin
					src_q   <= VW'(from_v);
					dst_q   <= VW'(to_v);
					top_v_q <= VW'(from_v);
					top_j_q <= '0;
					n_q     <= NW'(n_c);
				end
			end
			ST_SCAN: begin
				if (push) begin
					top_v_q <= col_j;
					top_j_q <= '0;
				end else if (!scan_end) begin
					top_j_q <= top_j_q + NW'(1);
				end
			end
			ST_POP: begin
				top_v_q <= stk_rd_q.v;
				top_j_q <= stk_rd_q.j;
			end
			ST_CHECK: begin
				cur_q <= dst_q;
				len_q <= '0;
			end
			ST_PATH: begin
				len_q <= len_q + LenW'(1);
				idx_q <= len_q[PathIdxW-1:0];
			end
			ST_PARENT: cur_q <= par_rd_q;
			ST_EMIT: begin
				if (out_free) begin
					m_vertex_q <= path_buf[idx_q];
					m_found_q  <= 1'b1;
					m_last_q   <= (idx_q == '0);
					idx_q      <= idx_q - PathIdxW'(1);
				end
			end
			ST_MISS: begin
				if (out_free) begin
					m_vertex_q <= '0;
					m_found_q  <= 1'b0;
					m_last_q   <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	// walk stack, parent links and path buffer
	always_ff @(posedge clk) begin
		if (push) begin
			stk_mem[sp_q]     <= '{v: top_v_q, j: top_j_q + NW'(1)};
			parent_mem[col_j] <= top_v_q;
		end
		stk_rd_q <= stk_mem[stk_raddr];
		par_rd_q <= parent_mem[cur_q];
		if (state_q == ST_PATH) path_buf[len_q[PathIdxW-1:0]] <= VertexW'(cur_q);
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = MTdataW'(m_vertex_q);
	assign m_axis_tuser  = m_found_q;
	assign m_axis_tlast  = m_last_q;

	`DFS_ASSERT(a_src_visited, clk, arst_n, (state_q == ST_FETCH) |-> visited_q[src_q], "search source not marked visited")
	`DFS_ASSERT_NEXT(a_push_top, clk, arst_n, push, (state_q == ST_FETCH) && visited_q[top_v_q], "pushed vertex not on top or not visited")
	`DFS_ASSERT(a_sp_bound, clk, arst_n, (state_q == ST_SCAN) |-> (NW'(sp_q) < n_q), "walk stack deeper than vertex count")
	`DFS_ASSERT(a_miss_last, clk, arst_n, (m_valid_q && !m_found_q) |-> m_last_q, "not-found transfer without last")

endmodule

`default_nettype wire
